// ----- sv/pwv_pkg.sv -----
package pwv_pkg;

  // Default sizes of the neighbor limit and of the kernel lookup.
  localparam int unsigned DefMaxNeighbors  = 1024;
  localparam int unsigned DefExpTableDepth = 256;

  // Fixed field widths.
  localparam int DistW  = 16;
  localparam int CfgW   = 16;
  localparam int KernW  = 16;
  localparam int DecW   = 16;
  localparam int SumW   = 32;
  localparam int CountW = 11;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // Derived widths of the final ratio arithmetic.
  localparam int ProdW = SumW + CountW;          // pos_sum * neg_count
  localparam int TotW  = ProdW + 1;              // A + B
  localparam int EpcW  = CfgW + CountW;          // eps * pos_count
  localparam int LimW  = EpcW + CountW;          // eps * pos_count * neg_count
  localparam int NumW  = TotW + DecW;            // dividend of the rounded ratio
  localparam int DivSteps = DecW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [CountW-1:0] CountMax  = '1;
  localparam logic [DecW-1:0]   DecPosMax = 16'h7FFF;
  localparam logic [DecW-1:0]   DecNegMax = 16'h8001;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] InvBwReset  = 16'd256;
  localparam logic [CfgW-1:0] MinKerReset = 16'd0;
  localparam logic [CfgW-1:0] EpsReset    = 16'd1;

  localparam logic [63:0] OneQ30 = 64'd1 << 30;

  typedef enum logic [1:0] {
    OUTCOME_NONE  = 2'd0,
    OUTCOME_NEG   = 2'd1,
    OUTCOME_POS   = 2'd2,
    OUTCOME_MIXED = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    REG_INV_BW  = 2'd0,
    REG_MIN_KER = 2'd1,
    REG_EPS     = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_IDX,
    S_ROM,
    S_ACC,
    S_FIN_MUL,
    S_FIN_SUM,
    S_FIN_CHK,
    S_DIV,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic idx;
    logic rom;
    logic acc;
    logic fin_mul;
    logic fin_sum;
    logic fin_chk;
    logic div_step;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic need_div;
    logic div_done;
    logic out_free;
  } status_t;

  // Division of a series term by its small term index.
  function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
    logic [63:0] r;
    case (k)
      1:  r = v;
      2:  r = v / 2;
      3:  r = v / 3;
      4:  r = v / 4;
      5:  r = v / 5;
      6:  r = v / 6;
      7:  r = v / 7;
      8:  r = v / 8;
      9:  r = v / 9;
      10: r = v / 10;
      11: r = v / 11;
      12: r = v / 12;
      13: r = v / 13;
      14: r = v / 14;
      15: r = v / 15;
      16: r = v / 16;
      17: r = v / 17;
      18: r = v / 18;
      19: r = v / 19;
      20: r = v / 20;
      21: r = v / 21;
      22: r = v / 22;
      23: r = v / 23;
      24: r = v / 24;
      default: r = v;
    endcase
    return r;
  endfunction

  // One kernel entry: exp(-u/2^26) in Q0.16 from u in Q2.30 scaled by 1/16.
  // The series gives exp(-u), four squarings raise it to the sixteenth power.
  function automatic logic [KernW-1:0] exp_from_u(input logic [63:0] u);
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        t;
    term = OneQ30;
    acc  = $signed(OneQ30);
    for (int k = 1; k <= 24; k++) begin
      term = div_small((term * u) >> 30, k);
      if (k[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    t = acc[63] ? 64'd0 : $unsigned(acc);
    if (t > OneQ30) begin
      t = OneQ30;
    end
    for (int s = 0; s < 4; s++) begin
      t = (t * t + (OneQ30 >> 1)) >> 30;
    end
    t = (t + 64'd8192) >> 14;
    return (t > 64'd65535) ? 16'hFFFF : t[KernW-1:0];
  endfunction

endpackage

// ----- sv/pwv_ctrl.sv -----
module pwv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pwv_pkg::status_t  status_i,
  output pwv_pkg::cmd_t     cmd_o
);

  pwv_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwv_pkg::S_IDLE:    if (in_valid_i) state_d = pwv_pkg::S_MUL;
      pwv_pkg::S_MUL:     state_d = pwv_pkg::S_IDX;
      pwv_pkg::S_IDX:     state_d = pwv_pkg::S_ROM;
      pwv_pkg::S_ROM:     state_d = pwv_pkg::S_ACC;
      pwv_pkg::S_ACC:     state_d = status_i.last ? pwv_pkg::S_FIN_MUL : pwv_pkg::S_IDLE;
      pwv_pkg::S_FIN_MUL: state_d = pwv_pkg::S_FIN_SUM;
      pwv_pkg::S_FIN_SUM: state_d = pwv_pkg::S_FIN_CHK;
      pwv_pkg::S_FIN_CHK: state_d = status_i.need_div ? pwv_pkg::S_DIV : pwv_pkg::S_EMIT;
      pwv_pkg::S_DIV:     if (status_i.div_done) state_d = pwv_pkg::S_EMIT;
      pwv_pkg::S_EMIT:    if (status_i.out_free) state_d = pwv_pkg::S_IDLE;
      default:            state_d = pwv_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      pwv_pkg::S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      pwv_pkg::S_MUL:     cmd_o.mul      = 1'b1;
      pwv_pkg::S_IDX:     cmd_o.idx      = 1'b1;
      pwv_pkg::S_ROM:     cmd_o.rom      = 1'b1;
      pwv_pkg::S_ACC:     cmd_o.acc      = 1'b1;
      pwv_pkg::S_FIN_MUL: cmd_o.fin_mul  = 1'b1;
      pwv_pkg::S_FIN_SUM: cmd_o.fin_sum  = 1'b1;
      pwv_pkg::S_FIN_CHK: cmd_o.fin_chk  = 1'b1;
      pwv_pkg::S_DIV:     cmd_o.div_step = 1'b1;
      pwv_pkg::S_EMIT:    cmd_o.emit     = status_i.out_free;
      default:            cmd_o          = '0;
    endcase
  end

`ifndef SYNTH
  // A result is only written when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result written into a full output register");
`endif

endmodule

// ----- sv/pwv_datapath.sv -----
module pwv_datapath #(
  parameter int unsigned MaxNeighbors  = pwv_pkg::DefMaxNeighbors,
  parameter int unsigned ExpTableDepth = pwv_pkg::DefExpTableDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pwv_pkg::cmd_t               cmd_i,
  output pwv_pkg::status_t            status_o,
  input  logic [pwv_pkg::DistW-1:0]   distance_i,
  input  logic                        label_positive_i,
  input  logic                        last_neighbor_i,
  input  logic [pwv_pkg::CfgW-1:0]    inv_bw_i,
  input  logic [pwv_pkg::CfgW-1:0]    min_kernel_i,
  input  logic [pwv_pkg::CfgW-1:0]    eps_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pwv_pkg::DecW-1:0]    decision_o,
  output logic [1:0]                  outcome_o
);

  localparam int IdxW    = $clog2(ExpTableDepth);
  localparam int XW      = 3 * pwv_pkg::DistW;
  localparam int XLowW   = 28;
  localparam int IdxProdW = XLowW + $clog2(ExpTableDepth + 1);

  // Kernel table: entry i holds exp(-16*i/depth), built at elaboration.
  logic [pwv_pkg::KernW-1:0] kernel_rom [ExpTableDepth];
  for (genvar g = 0; g < ExpTableDepth; g++) begin : g_rom
    localparam logic [63:0] EntryU = (64'(g) << 30) / ExpTableDepth;
    assign kernel_rom[g] = pwv_pkg::exp_from_u(EntryU);
  end

  // Kernel pipeline registers.
  logic [2*pwv_pkg::DistW-1:0] sq_q;
  logic [XW-1:0]               x_q;
  logic [IdxW-1:0]             idx_q;
  logic                        ovf_q;
  logic [pwv_pkg::KernW-1:0]   kern_q;
  logic                        pos_q;
  logic                        last_q;
  logic [IdxProdW-1:0]         idx_prod;

  // Square at capture, scale by 1/h^2, then form the table index.
  assign idx_prod = IdxProdW'(x_q[XLowW-1:0]) * IdxProdW'(ExpTableDepth);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sq_q   <= (2*pwv_pkg::DistW)'(distance_i) * (2*pwv_pkg::DistW)'(distance_i);
      pos_q  <= label_positive_i;
      last_q <= last_neighbor_i;
    end
    if (cmd_i.mul) begin
      x_q <= XW'(sq_q) * XW'(inv_bw_i);
    end
    if (cmd_i.idx) begin
      idx_q <= idx_prod[XLowW +: IdxW];
      ovf_q <= |x_q[XW-1:XLowW];
    end
    if (cmd_i.rom) begin
      kern_q <= ovf_q ? '0 : kernel_rom[idx_q];
    end
  end

  // Per-query accumulators.
  logic [pwv_pkg::SumW-1:0]   pos_sum_q, neg_sum_q;
  logic [pwv_pkg::CountW-1:0] pos_count_q, neg_count_q;
  logic                       stopped_q;
  logic [pwv_pkg::CountW:0]   total;
  logic                       room;
  logic [pwv_pkg::SumW:0]     pos_add, neg_add;

  assign total   = {1'b0, pos_count_q} + {1'b0, neg_count_q};
  assign room    = 32'(total) < 32'(MaxNeighbors);
  assign pos_add = {1'b0, pos_sum_q} + (pwv_pkg::SumW+1)'(kern_q);
  assign neg_add = {1'b0, neg_sum_q} + (pwv_pkg::SumW+1)'(kern_q);

  // Add the kernel to its class, or stop the query on a small kernel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_sum_q   <= '0;
      neg_sum_q   <= '0;
      pos_count_q <= '0;
      neg_count_q <= '0;
      stopped_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      pos_sum_q   <= '0;
      neg_sum_q   <= '0;
      pos_count_q <= '0;
      neg_count_q <= '0;
      stopped_q   <= 1'b0;
    end else if (cmd_i.acc && !stopped_q && room) begin
      if (kern_q < min_kernel_i) begin
        stopped_q <= 1'b1;
      end else if (pos_q) begin
        if (pos_count_q != pwv_pkg::CountMax) begin
          pos_sum_q   <= pos_add[pwv_pkg::SumW] ? '1 : pos_add[pwv_pkg::SumW-1:0];
          pos_count_q <= pos_count_q + 1'b1;
        end
      end else if (neg_count_q != pwv_pkg::CountMax) begin
        neg_sum_q   <= neg_add[pwv_pkg::SumW] ? '1 : neg_add[pwv_pkg::SumW-1:0];
        neg_count_q <= neg_count_q + 1'b1;
      end
    end
  end

  // Cross products of the class means and the tiny-sum limit.
  logic [pwv_pkg::ProdW-1:0] a_q, b_q, diff_q;
  logic [pwv_pkg::EpcW-1:0]  epc_q;
  logic [pwv_pkg::TotW-1:0]  s_q;
  logic [pwv_pkg::LimW-1:0]  lim_q;
  logic                      gt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_mul) begin
      a_q   <= pwv_pkg::ProdW'(pos_sum_q) * pwv_pkg::ProdW'(neg_count_q);
      b_q   <= pwv_pkg::ProdW'(neg_sum_q) * pwv_pkg::ProdW'(pos_count_q);
      epc_q <= pwv_pkg::EpcW'(eps_i) * pwv_pkg::EpcW'(pos_count_q);
    end
    if (cmd_i.fin_sum) begin
      s_q    <= pwv_pkg::TotW'(a_q) + pwv_pkg::TotW'(b_q);
      gt_q   <= a_q > b_q;
      diff_q <= (a_q > b_q) ? (a_q - b_q) : (b_q - a_q);
      lim_q  <= pwv_pkg::LimW'(epc_q) * pwv_pkg::LimW'(neg_count_q);
    end
  end

  // Special cases and the choice to divide.
  logic [pwv_pkg::DecW-1:0] chk_dec;
  logic [1:0]               chk_outc;
  logic                     chk_div;
  logic                     tiny;
  logic [pwv_pkg::NumW-1:0] num;

  assign tiny = s_q < pwv_pkg::TotW'(lim_q);
  assign num  = (pwv_pkg::NumW'(diff_q) << (pwv_pkg::DecW - 1))
              + pwv_pkg::NumW'(s_q >> 1);

  always_comb begin
    chk_dec  = '0;
    chk_outc = pwv_pkg::OUTCOME_MIXED;
    chk_div  = 1'b0;
    if (pos_count_q == '0 && neg_count_q == '0) begin
      chk_outc = pwv_pkg::OUTCOME_NONE;
    end else if (pos_count_q == '0) begin
      chk_outc = pwv_pkg::OUTCOME_NEG;
      chk_dec  = pwv_pkg::DecNegMax;
    end else if (neg_count_q == '0) begin
      chk_outc = pwv_pkg::OUTCOME_POS;
      chk_dec  = pwv_pkg::DecPosMax;
    end else if (gt_q) begin
      chk_dec = pwv_pkg::DecPosMax;
      chk_div = !tiny;
    end else begin
      chk_dec = pwv_pkg::DecNegMax;
      chk_div = !tiny && (s_q != '0);
    end
  end

  // Restoring divider for the rounded ratio, one quotient bit a cycle.
  logic [pwv_pkg::DecW-1:0]    dec_q, quo_q, nlow_q;
  logic [1:0]                  outc_q;
  logic                        nd_q;
  logic [pwv_pkg::TotW-1:0]    rem_q;
  logic [pwv_pkg::DivCntW-1:0] cnt_q;
  logic [pwv_pkg::TotW:0]      r2, r2_sub;
  logic                        ge;

  assign r2     = {rem_q, nlow_q[pwv_pkg::DecW-1]};
  assign r2_sub = r2 - {1'b0, s_q};
  assign ge     = r2 >= {1'b0, s_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_chk) begin
      dec_q  <= chk_dec;
      outc_q <= chk_outc;
      nd_q   <= chk_div;
      rem_q  <= num[pwv_pkg::NumW-1:pwv_pkg::DecW];
      nlow_q <= num[pwv_pkg::DecW-1:0];
      quo_q  <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? r2_sub[pwv_pkg::TotW-1:0] : r2[pwv_pkg::TotW-1:0];
      nlow_q <= {nlow_q[pwv_pkg::DecW-2:0], 1'b0};
      quo_q  <= {quo_q[pwv_pkg::DecW-2:0], ge};
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  // Saturate the quotient and give it the sign of the larger mean; without a division the checked decision passes.
  logic [pwv_pkg::DecW-1:0] mag, fin_dec;

  assign mag     = (quo_q > pwv_pkg::DecPosMax) ? pwv_pkg::DecPosMax : quo_q;
  assign fin_dec = !nd_q ? dec_q : (gt_q ? mag : (~mag + 1'b1));

  // Output register.
  logic                     out_valid_q;
  logic [pwv_pkg::DecW-1:0] out_dec_q;
  logic [1:0]               out_outc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_dec_q  <= fin_dec;
      out_outc_q <= outc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign decision_o  = out_dec_q;
  assign outcome_o   = out_outc_q;

  assign status_o.last     = last_q;
  assign status_o.need_div = chk_div;
  assign status_o.div_done = cnt_q == pwv_pkg::DivCntW'(pwv_pkg::DivSteps - 1);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

`ifndef SYNTH
  // The neighbor count of a query never passes the limit.
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total) <= 32'(MaxNeighbors))
    else $error("neighbor count beyond limit");

  // Writing a result clears the query state.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (pos_count_q == '0 && neg_count_q == '0 && !stopped_q))
    else $error("query state not cleared after result");

  // An empty query reports a zero decision.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_outc_q == pwv_pkg::OUTCOME_NONE) |-> out_dec_q == '0)
    else $error("empty query with nonzero decision");
`endif

endmodule

// ----- sv/parzen_window_vote_core.sv -----
// Parzen-window vote core.
// The input channel takes one neighbor of a query per request: its Q8.8
// distance, whether its label is positive, and a flag on the last neighbor.
// Each neighbor's Gaussian kernel is looked up and added to its class sum.
// On the last neighbor one result request follows on the output channel:
// a Q1.15 decision in [-0x7FFF,+0x7FFF] and an outcome code. Other neighbors give none.
// An input request is taken in the idle state only; each neighbor passes
// the kernel path (square, scale, index, table read, accumulate) before the
// core returns to idle, so the input takes no request while it is busy.
// After the last neighbor the cross products, their sum and a check follow;
// the result is written directly when a special case decides it, and
// otherwise after the restoring divider forms the ratio.
// The result waits in an output register while the receiver stalls; the
// core finishes the next query up to that register and holds there until
// the output is taken.
// Reset clears the query state and the output valid and loads the
// registers with their defaults; no clearing pass is needed.
// Registers on the APB port: 0x0 1/h^2, 0x4 minimum kernel, 0x8 epsilon.
module parzen_window_vote_core #(
  parameter int unsigned MaxNeighbors  = pwv_pkg::DefMaxNeighbors,
  parameter int unsigned ExpTableDepth = pwv_pkg::DefExpTableDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pwv_pkg::DistW-1:0]          distance_i,
  input  logic                               label_positive_i,
  input  logic                               last_neighbor_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [pwv_pkg::DecW-1:0]    decision_o,
  output logic [1:0]                         outcome_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwv_pkg::AddrW-1:0]          paddr,
  input  logic [pwv_pkg::DataW-1:0]          pwdata,
  output logic [pwv_pkg::DataW-1:0]          prdata,
  output logic                               pready
);

  logic [pwv_pkg::CfgW-1:0] inv_bw_q, min_kernel_q, eps_q;
  logic                     wr_en;
  logic [1:0]               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_bw_q     <= pwv_pkg::InvBwReset;
      min_kernel_q <= pwv_pkg::MinKerReset;
      eps_q        <= pwv_pkg::EpsReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        pwv_pkg::REG_INV_BW:  inv_bw_q     <= pwdata[pwv_pkg::CfgW-1:0];
        pwv_pkg::REG_MIN_KER: min_kernel_q <= pwdata[pwv_pkg::CfgW-1:0];
        pwv_pkg::REG_EPS:     eps_q        <= pwdata[pwv_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      pwv_pkg::REG_INV_BW:  prdata = pwv_pkg::DataW'(inv_bw_q);
      pwv_pkg::REG_MIN_KER: prdata = pwv_pkg::DataW'(min_kernel_q);
      pwv_pkg::REG_EPS:     prdata = pwv_pkg::DataW'(eps_q);
      default:              prdata = '0;
    endcase
  end

  pwv_pkg::cmd_t            cmd;
  pwv_pkg::status_t         status;
  logic [pwv_pkg::DecW-1:0] decision;

  pwv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pwv_datapath #(
    .MaxNeighbors  (MaxNeighbors),
    .ExpTableDepth (ExpTableDepth)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .distance_i       (distance_i),
    .label_positive_i (label_positive_i),
    .last_neighbor_i  (last_neighbor_i),
    .inv_bw_i         (inv_bw_q),
    .min_kernel_i     (min_kernel_q),
    .eps_i            (eps_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .decision_o       (decision),
    .outcome_o        (outcome_o)
  );

  assign decision_o = $signed(decision);

endmodule
